// ----- hdl/smds_pkg.sv -----
package smds_pkg;

	localparam int SAMPLE_W = 32;
	localparam int SUM_W    = 38;
	localparam int LEN_W    = 7;

	// Command handed from the front to the back over a valid/ready handshake.
	typedef struct packed {
		logic                       has_old;  // window full: remove the oldest sample
		logic                       emit;     // this sample yields a result
		logic signed [SAMPLE_W-1:0] old_smp;
		logic signed [SAMPLE_W-1:0] new_smp;
	} smds_cmd_t;

	typedef enum logic [1:0] {
		BK_IDLE,
		BK_SUM,
		BK_OUT
	} smds_bk_state_t;

endpackage

// ----- hdl/sliding_median_deviation_sum.sv -----
// Path: the front registers the accepted sample, the back then updates the sorted store,
// sums the deviations serially over the window samples, and moves the sum into the output register.
// The back takes no new sample while a sum runs or waits for the output register; the serial sum sets the throughput.
// Samples that only fill the window yield no result and need no sum pass in the back.
// Reset: arst_n clears the window (no samples held) and sets window_len to 3.
module sliding_median_deviation_sum import smds_pkg::*; #(
	parameter int MAX_WINDOW = 64
) (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       push,
	output logic                       full,
	input  logic signed [SAMPLE_W-1:0] sample,
	input  logic                       window_len_we,
	input  logic [LEN_W-1:0]           window_len,
	output logic                       empty,
	input  logic                       pop,
	output logic [SUM_W-1:0]           deviation_sum
);

	localparam int PTR_W = (MAX_WINDOW > 1) ? $clog2(MAX_WINDOW) : 1;

	smds_cmd_t cmd;
	logic      cmd_valid;
	logic      cmd_ready;
	logic      res_valid;

	// The front keeps the ring and looks up the sample that leaves the window.
	smds_front #(.MAX_WINDOW(MAX_WINDOW), .PTR_W(PTR_W)) u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.full      (full),
		.sample    (sample),
		.cfg_we    (window_len_we),
		.cfg_len   (window_len),
		.cmd_valid (cmd_valid),
		.cmd       (cmd),
		.cmd_ready (cmd_ready)
	);

	// The back updates the sorted store and sums the deviations. A finished sum moves
	// into an output register, so the back can start the next item while it waits.
	smds_back #(.MAX_WINDOW(MAX_WINDOW), .PTR_W(PTR_W)) u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (window_len_we),
		.cmd_valid (cmd_valid),
		.cmd       (cmd),
		.cmd_ready (cmd_ready),
		.res_valid (res_valid),
		.res_sum   (deviation_sum),
		.res_taken (pop)
	);

	assign empty = !res_valid;

endmodule

// ----- hdl/smds_front.sv -----
module smds_front import smds_pkg::*; #(
	parameter int MAX_WINDOW = 64,
	parameter int PTR_W      = 6
) (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       push,
	output logic                       full,
	input  logic signed [SAMPLE_W-1:0] sample,
	input  logic                       cfg_we,
	input  logic [LEN_W-1:0]           cfg_len,
	output logic                       cmd_valid,
	output smds_cmd_t                  cmd,
	input  logic                       cmd_ready
);

	localparam int CNT_W = PTR_W + 1;

	logic signed [SAMPLE_W-1:0] ring_q [MAX_WINDOW];
	logic [CNT_W-1:0]           len_q;
	logic [CNT_W-1:0]           fill_q;
	logic [PTR_W-1:0]           ptr_q;
	logic signed [SAMPLE_W-1:0] new_s1;
	logic                       busy_s1;
	logic                       has_old_s1;
	logic                       emit_s1;
	logic signed [SAMPLE_W-1:0] old_s1;
	logic                       accept;
	logic [CNT_W-1:0]           ptr_next;
	logic [LEN_W-1:0]           clamped;

	// Stage one holds the accepted sample and its ring read until the back takes them.
	assign full   = busy_s1;
	assign accept = push && !busy_s1;

	always_comb begin
		clamped = cfg_len;
		if (cfg_len == '0) begin
			clamped = LEN_W'(1);
		end else if (32'(cfg_len) > MAX_WINDOW) begin
			clamped = LEN_W'(MAX_WINDOW);
		end
	end

	assign ptr_next = (CNT_W'(ptr_q) + CNT_W'(1) >= len_q) ? '0 : CNT_W'(ptr_q) + CNT_W'(1);

	always_ff @(posedge clk) begin
		if (accept) begin
			old_s1       <= ring_q[ptr_q];
			ring_q[ptr_q] <= sample;
			new_s1       <= sample;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			len_q      <= CNT_W'(3);
			fill_q     <= '0;
			ptr_q      <= '0;
			busy_s1    <= 1'b0;
			has_old_s1 <= 1'b0;
			emit_s1    <= 1'b0;
		end else begin
			if (cfg_we) begin
				len_q  <= CNT_W'(clamped);
				fill_q <= '0;
				ptr_q  <= '0;
			end else if (accept) begin
				has_old_s1 <= (fill_q == len_q);
				emit_s1    <= (fill_q + CNT_W'(1) >= len_q);
				if (fill_q != len_q) begin
					fill_q <= fill_q + CNT_W'(1);
				end
				ptr_q <= ptr_next[PTR_W-1:0];
			end
			if (accept) begin
				busy_s1 <= 1'b1;
			end else if (cmd_ready) begin
				busy_s1 <= 1'b0;
			end
		end
	end

	assign cmd_valid     = busy_s1;
	assign cmd.has_old   = has_old_s1;
	assign cmd.emit      = emit_s1;
	assign cmd.old_smp   = old_s1;
	assign cmd.new_smp   = new_s1;

endmodule

// ----- hdl/smds_back.sv -----
module smds_back import smds_pkg::*; #(
	parameter int MAX_WINDOW = 64,
	parameter int PTR_W      = 6
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 cfg_we,
	input  logic                 cmd_valid,
	input  smds_cmd_t            cmd,
	output logic                 cmd_ready,
	output logic                 res_valid,
	output logic [SUM_W-1:0]     res_sum,
	input  logic                 res_taken
);

	localparam int CNT_W = PTR_W + 1;

	// Sorted store as a chain of cells; each cell decides its own shift.
	logic signed [SAMPLE_W-1:0] srt_q [MAX_WINDOW];
	logic [CNT_W-1:0]           cnt_q;
	logic signed [SAMPLE_W-1:0] nxt   [MAX_WINDOW];
	logic signed [SAMPLE_W-1:0] rem   [MAX_WINDOW];
	logic [MAX_WINDOW-1:0]      found;
	logic [MAX_WINDOW-1:0]      gt;
	logic [CNT_W-1:0]           rcnt;
	smds_bk_state_t             st_q, st_d;
	logic signed [SAMPLE_W-1:0] med_q;
	logic [CNT_W-1:0]           idx_q;
	logic [SUM_W-1:0]           acc_q;
	logic signed [SAMPLE_W:0]   diff;
	logic [SAMPLE_W:0]          absd;
	logic                       take;
	logic [PTR_W-1:0]           mid_idx;
	logic                       res_valid_q;
	logic [SUM_W-1:0]           res_sum_q;
	logic                       out_free;

	// Removal: find the first copy of the old sample and close the gap.
	always_comb begin
		for (int i = 0; i < MAX_WINDOW; i++) begin
			found[i] = (CNT_W'(i) < cnt_q) && (srt_q[i] == cmd.old_smp);
		end
		for (int i = 0; i < MAX_WINDOW; i++) begin
			logic prior;
			prior = 1'b0;
			for (int j = 0; j <= i; j++) prior = prior | found[j];
			if (cmd.has_old && prior && i + 1 < MAX_WINDOW) rem[i] = srt_q[(i + 1) % MAX_WINDOW];
			else rem[i] = srt_q[i];
		end
		rcnt = cmd.has_old ? cnt_q - CNT_W'(1) : cnt_q;
		for (int i = 0; i < MAX_WINDOW; i++) begin
			gt[i] = (CNT_W'(i) < rcnt) && ($signed(rem[i]) > $signed(cmd.new_smp));
		end
		// Insertion: cells above the new sample shift up by one.
		for (int i = 0; i < MAX_WINDOW; i++) begin
			if (gt[i]) begin
				nxt[i] = (i > 0 && gt[(i + MAX_WINDOW - 1) % MAX_WINDOW])
				         ? rem[(i + MAX_WINDOW - 1) % MAX_WINDOW] : cmd.new_smp;
			end else if (CNT_W'(i) == rcnt) begin
				nxt[i] = (i > 0 && gt[(i + MAX_WINDOW - 1) % MAX_WINDOW])
				         ? rem[(i + MAX_WINDOW - 1) % MAX_WINDOW] : cmd.new_smp;
			end else begin
				nxt[i] = rem[i];
			end
		end
	end

	// Upper median position of the updated store.
	assign mid_idx = PTR_W'((rcnt + CNT_W'(1)) >> 1);

	assign take      = cmd_valid && (st_q == BK_IDLE);
	assign cmd_ready = (st_q == BK_IDLE);
	assign out_free  = !res_valid_q || res_taken;

	always_comb begin
		st_d = st_q;
		case (st_q)
			BK_IDLE: if (take && cmd.emit) st_d = BK_SUM;
			BK_SUM:  if (idx_q + CNT_W'(1) >= cnt_q) st_d = BK_OUT;
			BK_OUT:  if (out_free) st_d = BK_IDLE;
			default: st_d = BK_IDLE;
		endcase
	end

	assign diff = {srt_q[idx_q[PTR_W-1:0]][SAMPLE_W-1], srt_q[idx_q[PTR_W-1:0]]}
	            - {med_q[SAMPLE_W-1], med_q};
	assign absd = diff[SAMPLE_W] ? (SAMPLE_W+1)'(-diff) : (SAMPLE_W+1)'(diff);

	always_ff @(posedge clk) begin
		if (take) begin
			for (int i = 0; i < MAX_WINDOW; i++) srt_q[i] <= nxt[i];
			med_q <= nxt[mid_idx];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q        <= BK_IDLE;
			cnt_q       <= '0;
			idx_q       <= '0;
			acc_q       <= '0;
			res_valid_q <= 1'b0;
			res_sum_q   <= '0;
		end else begin
			st_q <= st_d;
			if (cfg_we) begin
				cnt_q <= '0;
			end else if (take) begin
				cnt_q <= rcnt + CNT_W'(1);
			end
			if (take) begin
				idx_q <= '0;
				acc_q <= '0;
			end else if (st_q == BK_SUM) begin
				idx_q <= idx_q + CNT_W'(1);
				acc_q <= acc_q + SUM_W'(absd);
			end
			if (st_q == BK_OUT && out_free) begin
				res_valid_q <= 1'b1;
				res_sum_q   <= acc_q;
			end else if (res_taken) begin
				res_valid_q <= 1'b0;
			end
		end
	end

	assign res_valid = res_valid_q;
	assign res_sum   = res_sum_q;

endmodule
